// File: hw/rtl/cau_pkg.sv
// shared types, constants and helper functions for the complex arithmetic unit
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NUM_W      = SUM_W + FRAC_BITS;
    localparam int QUO_W      = DATA_WIDTH;
    localparam int REM_W      = PROD_W;
    localparam int CMP_W      = REM_W + QUO_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        op_t                          operation;
        logic signed [DATA_WIDTH-1:0] first_real;
        logic signed [DATA_WIDTH-1:0] first_imag;
        logic signed [DATA_WIDTH-1:0] second_real;
        logic signed [DATA_WIDTH-1:0] second_imag;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_real;
        logic signed [DATA_WIDTH-1:0] result_imag;
        status_t                      status;
    } cau_out_t;

    // values that ride alongside the divider
    typedef struct packed {
        op_t                     op;
        logic signed [SUM_W-1:0] pre_re;
        logic signed [SUM_W-1:0] pre_im;
        logic                    neg_re;
        logic                    neg_im;
        logic                    ovf_re;
        logic                    ovf_im;
        logic                    div_zero;
    } pass_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        pass_t            pass;
        lane_t            re;
        lane_t            im;
        logic [REM_W-1:0] den;
    } stage_t;

    // one restoring division step, quotient bits shift in from the bottom
    function automatic lane_t div_step(lane_t l, logic [REM_W-1:0] den);
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        logic           ge;
        lane_t          r;
        t      = {l.rem, l.quo[QUO_W-1]};
        diff   = t - {1'b0, den};
        ge     = (t >= {1'b0, den});
        r.rem  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        r.quo  = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    // clamp to the signed data range, msb of the result is the clamp flag
    function automatic logic [DATA_WIDTH:0] saturate(logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
        lo_lim = -(SUM_W'(1) <<< (DATA_WIDTH - 1));
        if (x > hi_lim) begin
            return {1'b1, hi_lim[DATA_WIDTH-1:0]};
        end
        if (x < lo_lim) begin
            return {1'b1, lo_lim[DATA_WIDTH-1:0]};
        end
        return {1'b0, x[DATA_WIDTH-1:0]};
    endfunction

endpackage

// File: hw/rtl/complex_arith_unit.sv
// top level of the pipelined complex add, subtract, multiply and divide unit
// an accepted src beat passes 3 front stages, 32 quotient steps and 1 output
//   register on its way to its dst beat
// throughput: one beat per cycle unless dst stalls (unrolled 32-step divider)
// the whole pipe freezes while a finished beat waits under dst_stall
// reset: rst_n clears every valid bit at once; data registers are not reset
module complex_arith_unit
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  cau_in_t  src_data,
    output logic     dst_valid,
    input  logic     dst_stall,
    output cau_out_t dst_data
);

    // pipe moves whenever the output register is empty or being taken
    logic             advance;

    // divider chain, index 0 is the setup stage
    logic [QUO_W:0]   chain_valid;
    stage_t           chain_stage [QUO_W+1];

    // output register
    logic             out_valid_reg;
    cau_out_t         out_reg, out_next;

    // final selection
    stage_t                  last;
    logic signed [SUM_W-1:0] val_re, val_im;
    logic [DATA_WIDTH:0]     sat_re, sat_im;

    assign advance   = !out_valid_reg || !dst_stall;
    assign src_stall = !advance;

    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .src_valid  (src_valid),
        .src_data   (src_data),
        .init_valid (chain_valid[0]),
        .init_stage (chain_stage[0])
    );

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        cau_div_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (chain_valid[i]),
            .prev_stage (chain_stage[i]),
            .cur_valid  (chain_valid[i+1]),
            .cur_stage  (chain_stage[i+1])
        );
    end

    assign last = chain_stage[QUO_W];

    always_comb
    begin
        // add, subtract and multiply already hold their unclamped value
        val_re = last.pass.pre_re;
        val_im = last.pass.pre_im;
        if (last.pass.op == OP_DIV)
        begin
            // signed quotient from magnitude, rounded toward zero
            val_re = last.pass.neg_re ? -SUM_W'(last.re.quo) : SUM_W'(last.re.quo);
            val_im = last.pass.neg_im ? -SUM_W'(last.im.quo) : SUM_W'(last.im.quo);
            // quotient too big for the lanes: push far past the clamp limit
            if (last.pass.ovf_re)
            begin
                val_re = last.pass.neg_re ? -(SUM_W'(1) <<< (SUM_W - 2))
                                          : (SUM_W'(1) <<< (SUM_W - 2));
            end
            if (last.pass.ovf_im)
            begin
                val_im = last.pass.neg_im ? -(SUM_W'(1) <<< (SUM_W - 2))
                                          : (SUM_W'(1) <<< (SUM_W - 2));
            end
        end
        sat_re = saturate(val_re);
        sat_im = saturate(val_im);

        if (last.pass.op == OP_DIV && last.pass.div_zero)
        begin
            // zero divisor gives zero parts and its own status
            out_next.result_real = '0;
            out_next.result_imag = '0;
            out_next.status      = ST_DIV0;
        end
        else
        begin
            out_next.result_real = sat_re[DATA_WIDTH-1:0];
            out_next.result_imag = sat_im[DATA_WIDTH-1:0];
            out_next.status      = (sat_re[DATA_WIDTH] || sat_im[DATA_WIDTH]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

endmodule

// File: hw/rtl/cau_front.sv
// front stages: products, sums and divider setup
module cau_front
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    src_valid,
    input  cau_in_t src_data,
    output logic    init_valid,
    output stage_t  init_stage
);

    // stage 1: products and add/subtract sums
    logic                         v1_reg;
    op_t                          op1_reg;
    logic signed [PROD_W-1:0]     ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [DATA_WIDTH:0]   as_re_reg, as_im_reg;
    logic signed [DATA_WIDTH:0]   as_re_next, as_im_next;

    // stage 2: sums
    logic                         v2_reg;
    op_t                          op2_reg;
    logic signed [SUM_W-1:0]      pre_re_reg, pre_im_reg, nre_reg, nim_reg;
    logic signed [SUM_W-1:0]      pre_re_next, pre_im_next;
    logic signed [SUM_W-1:0]      mre, mim;
    logic [REM_W-1:0]             den_reg;

    // stage 3: setup
    logic                         v3_reg;
    stage_t                       s3_reg, s3_next;
    logic signed [NUM_W-1:0]      num_re, num_im;
    logic [NUM_W-1:0]             mag_re, mag_im;

    always_comb
    begin
        if (src_data.operation == OP_SUB)
        begin
            as_re_next = (DATA_WIDTH+1)'(src_data.first_real) -
                         (DATA_WIDTH+1)'(src_data.second_real);
            as_im_next = (DATA_WIDTH+1)'(src_data.first_imag) -
                         (DATA_WIDTH+1)'(src_data.second_imag);
        end
        else
        begin
            as_re_next = (DATA_WIDTH+1)'(src_data.first_real) +
                         (DATA_WIDTH+1)'(src_data.second_real);
            as_im_next = (DATA_WIDTH+1)'(src_data.first_imag) +
                         (DATA_WIDTH+1)'(src_data.second_imag);
        end
    end

    always_comb
    begin
        mre = SUM_W'(ac_reg) - SUM_W'(bd_reg);
        mim = SUM_W'(ad_reg) + SUM_W'(bc_reg);
        unique case (op1_reg)
            OP_ADD, OP_SUB:
            begin
                pre_re_next = SUM_W'(as_re_reg);
                pre_im_next = SUM_W'(as_im_reg);
            end
            default:
            begin
                pre_re_next = mre >>> FRAC_BITS;
                pre_im_next = mim >>> FRAC_BITS;
            end
        endcase
    end

    always_comb
    begin
        num_re = {nre_reg, FRAC_BITS'(0)};
        num_im = {nim_reg, FRAC_BITS'(0)};
        mag_re = num_re[NUM_W-1] ? NUM_W'(-num_re) : NUM_W'(num_re);
        mag_im = num_im[NUM_W-1] ? NUM_W'(-num_im) : NUM_W'(num_im);
        s3_next.pass.op       = op2_reg;
        s3_next.pass.pre_re   = pre_re_reg;
        s3_next.pass.pre_im   = pre_im_reg;
        s3_next.pass.neg_re   = num_re[NUM_W-1];
        s3_next.pass.neg_im   = num_im[NUM_W-1];
        s3_next.pass.ovf_re   = (CMP_W'(mag_re) >= {den_reg, QUO_W'(0)});
        s3_next.pass.ovf_im   = (CMP_W'(mag_im) >= {den_reg, QUO_W'(0)});
        s3_next.pass.div_zero = (den_reg == '0);
        s3_next.re.rem        = REM_W'(mag_re >> QUO_W);
        s3_next.re.quo        = mag_re[QUO_W-1:0];
        s3_next.im.rem        = REM_W'(mag_im >> QUO_W);
        s3_next.im.quo        = mag_im[QUO_W-1:0];
        s3_next.den           = den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= src_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg    <= src_data.operation;
            ac_reg     <= PROD_W'(src_data.first_real) * PROD_W'(src_data.second_real);
            bd_reg     <= PROD_W'(src_data.first_imag) * PROD_W'(src_data.second_imag);
            ad_reg     <= PROD_W'(src_data.first_real) * PROD_W'(src_data.second_imag);
            bc_reg     <= PROD_W'(src_data.first_imag) * PROD_W'(src_data.second_real);
            cc_reg     <= PROD_W'(src_data.second_real) * PROD_W'(src_data.second_real);
            dd_reg     <= PROD_W'(src_data.second_imag) * PROD_W'(src_data.second_imag);
            as_re_reg  <= as_re_next;
            as_im_reg  <= as_im_next;

            op2_reg    <= op1_reg;
            pre_re_reg <= pre_re_next;
            pre_im_reg <= pre_im_next;
            nre_reg    <= SUM_W'(ac_reg) + SUM_W'(bd_reg);
            nim_reg    <= SUM_W'(bc_reg) - SUM_W'(ad_reg);
            den_reg    <= REM_W'(cc_reg) + REM_W'(dd_reg);

            s3_reg     <= s3_next;
        end
    end

    assign init_valid = v3_reg;
    assign init_stage = s3_reg;

endmodule

// File: hw/rtl/cau_div_step.sv
// one registered restoring step of the two quotient lanes
module cau_div_step
    import cau_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   prev_valid,
    input  stage_t prev_stage,
    output logic   cur_valid,
    output stage_t cur_stage
);

    logic   valid_reg;
    stage_t stage_reg, stage_next;

    always_comb
    begin
        stage_next    = prev_stage;
        stage_next.re = div_step(prev_stage.re, prev_stage.den);
        stage_next.im = div_step(prev_stage.im, prev_stage.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign cur_valid = valid_reg;
    assign cur_stage = stage_reg;

endmodule

// File: tb/complex_arith_unit_tb.sv
// self-checking testbench for the complex arithmetic unit
module complex_arith_unit_tb
    import cau_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RAND_ITEMS  = 1300;

    localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] ONE_V = DATA_WIDTH'(1) <<< FRAC_BITS;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_stall;
    cau_in_t  src_data;
    logic     dst_valid;
    logic     dst_stall;
    cau_out_t dst_data;

    // expected results, oldest first
    cau_out_t expected_results[$];
    int       fail_count;
    int       cycle_count;
    // sender idling off when set
    bit       src_steady;
    // receiver idling off when set
    bit       dst_steady;
    // the long receiver hold-off is requested by bumping this count
    int       hold_requests;

    complex_arith_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // clamp a wide value to the data range, flag the clamp
    function automatic logic [DATA_WIDTH-1:0] clamp_part(logic signed [127:0] x,
                                                        inout bit clamped);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = MAX_V;
        lo_lim = MIN_V;
        if (x > hi_lim)
        begin
            clamped = 1'b1;
            return MAX_V;
        end
        if (x < lo_lim)
        begin
            clamped = 1'b1;
            return MIN_V;
        end
        return x[DATA_WIDTH-1:0];
    endfunction

    // exact complex arithmetic at 128 bits, then saturation
    function automatic cau_out_t complex_result(cau_in_t item);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] d;
        logic signed [127:0] re;
        logic signed [127:0] im;
        logic signed [127:0] mag;
        bit                  clamped;
        cau_out_t            r;
        a = item.first_real;
        b = item.first_imag;
        c = item.second_real;
        d = item.second_imag;
        clamped = 1'b0;
        case (item.operation)
            OP_ADD:
            begin
                re = a + c;
                im = b + d;
            end
            OP_SUB:
            begin
                re = a - c;
                im = b - d;
            end
            OP_MUL:
            begin
                re = (a * c - b * d) >>> FRAC_BITS;
                im = (a * d + b * c) >>> FRAC_BITS;
            end
            default:
            begin
                mag = c * c + d * d;
                if (mag == 0)
                begin
                    r.result_real = '0;
                    r.result_imag = '0;
                    r.status      = ST_DIV0;
                    return r;
                end
                // signed division truncates toward zero
                re = ((a * c + b * d) <<< FRAC_BITS) / mag;
                im = ((b * c - a * d) <<< FRAC_BITS) / mag;
            end
        endcase
        r.result_real = clamp_part(re, clamped);
        r.result_imag = clamp_part(im, clamped);
        r.status      = clamped ? ST_SAT : ST_OK;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // operand values biased toward interesting corners
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(7))
            0: return MAX_V;
            1: return MIN_V;
            2: return '0;
            3: return DATA_WIDTH'($urandom_range(8)) - DATA_WIDTH'(4);
            4: return DATA_WIDTH'($signed($urandom_range(600000)) - 300000);
            5: return ONE_V * DATA_WIDTH'($urandom_range(6));
            default: return $urandom;
        endcase
    endfunction

    // offer one beat, hold it until accepted, then idle for the given gap, if any
    task automatic send_beat(cau_in_t item, int gap);
        src_valid <= 1'b1;
        src_data  <= item;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        expected_results.push_back(complex_result(item));
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(op_t op, logic signed [DATA_WIDTH-1:0] a,
                           logic signed [DATA_WIDTH-1:0] b,
                           logic signed [DATA_WIDTH-1:0] c,
                           logic signed [DATA_WIDTH-1:0] d);
        cau_in_t item;
        item.operation   = op;
        item.first_real  = a;
        item.first_imag  = b;
        item.second_real = c;
        item.second_imag = d;
        send_beat(item, src_steady ? 0 : pick_gap());
    endtask

    task automatic test_directed();
        send_op(OP_ADD, 1, 2, 3, 4);
        send_op(OP_ADD, MAX_V, MAX_V, MAX_V, 1);
        send_op(OP_ADD, MIN_V, MIN_V, MIN_V, -1);
        send_op(OP_SUB, MIN_V, MAX_V, MAX_V, MIN_V);
        send_op(OP_SUB, 0, 0, MIN_V, 0);
        send_op(OP_MUL, ONE_V, ONE_V, ONE_V, ONE_V);
        send_op(OP_MUL, MAX_V, MAX_V, MAX_V, MAX_V);
        send_op(OP_MUL, MIN_V, MIN_V, MIN_V, MIN_V);
        // negative products truncate toward minus infinity
        send_op(OP_MUL, -1, 1, 1, 1);
        send_op(OP_MUL, -3, 0, 5, 0);
        send_op(OP_DIV, ONE_V, ONE_V, 0, 0);
        send_op(OP_DIV, MIN_V, MAX_V, 0, 0);
        send_op(OP_DIV, ONE_V, 0, ONE_V, 0);
        send_op(OP_DIV, -1, 0, ONE_V, 0);
        send_op(OP_DIV, MIN_V, MIN_V, 1, 0);
        send_op(OP_DIV, MAX_V, MAX_V, MIN_V, MIN_V);
        send_op(OP_DIV, 7 * ONE_V, -3 * ONE_V, 2 * ONE_V, ONE_V);
        send_op(OP_DIV, 1, 1, MAX_V, MAX_V);
        send_op(OP_ADD, -1, -1, -1, -1);
        send_op(OP_MUL, -1, -1, -1, -1);
    endtask

    task automatic test_random(int count);
        cau_in_t item;
        for (int i = 0; i < count; i++)
        begin
            // stretches with no idling on the sender
            if (i % 200 == 0)
                src_steady = ($urandom_range(2) == 0);
            item.operation   = op_t'($urandom_range(3));
            item.first_real  = pick_value();
            item.first_imag  = pick_value();
            item.second_real = pick_value();
            item.second_imag = pick_value();
            // some zero divisors
            if (item.operation == OP_DIV && $urandom_range(15) == 0)
            begin
                item.second_real = '0;
                item.second_imag = '0;
            end
            send_beat(item, src_steady ? 0 : pick_gap());
        end
        src_steady = 1'b0;
    endtask

    // receiver holds off long while the sender keeps offering beats
    task automatic test_backpressure();
        hold_requests++;
        src_steady = 1'b1;
        for (int i = 0; i < 60; i++)
            send_op(op_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        src_steady = 1'b0;
    endtask

    // receiver side: random stalls plus the requested long hold-off
    initial
    begin : dst_side
        int hold_left;
        int seen_requests;
        int stall_left;
        hold_left     = 0;
        seen_requests = 0;
        stall_left    = 0;
        dst_stall     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != seen_requests)
            begin
                seen_requests = hold_requests;
                hold_left     = 300;
            end
            if (cycle_count % 2000 == 0)
                dst_steady = ($urandom_range(3) == 0);
            if (hold_left > 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                dst_stall <= 1'b1;
            end
            else if (!dst_steady && $urandom_range(3) == 0)
            begin
                stall_left = pick_gap();
                dst_stall <= 1'b1;
            end
            else
                dst_stall <= 1'b0;
        end
    end

    // compare each delivered beat with the oldest expectation
    always @(posedge clk)
    begin
        cau_out_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected beat, actual %h", $time, dst_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (dst_data.result_real !== want.result_real)
                begin
                    fail_count++;
                    $display("%0t: result_real expected %h actual %h", $time,
                             want.result_real, dst_data.result_real);
                end
                if (dst_data.result_imag !== want.result_imag)
                begin
                    fail_count++;
                    $display("%0t: result_imag expected %h actual %h", $time,
                             want.result_imag, dst_data.result_imag);
                end
                if (dst_data.status !== want.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %s actual %s", $time,
                             want.status.name(), dst_data.status.name());
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        fail_count    = 0;
        cycle_count   = 0;
        src_steady    = 1'b0;
        dst_steady    = 1'b0;
        hold_requests = 0;
        rst_n         = 1'b0;
        src_valid     = 1'b0;
        src_data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(RAND_ITEMS);
        src_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
